/* hw/rtl/pli_pkg.sv */
// Shared types and constants for the piecewise linear interpolator.
`timescale 1ns / 1ps

package pli_pkg;

  // Raw signed fixed point word; the fraction scale cancels in the math
  localparam int DATA_W = 32;
  typedef logic signed [DATA_W-1:0] q16_t;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Breakpoint count register
  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 5'd2;

  // Divider: quotient bits resolved per cycle and cycles per quotient
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = DATA_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Input item
  typedef struct packed {
    logic       kind;
    logic [3:0] point_index;
    q16_t       point_x;
    q16_t       point_y;
    q16_t       query_x;
  } in_item_t;

  // Result item; miss is set when no interval holds the query
  typedef struct packed {
    q16_t result_y;
    logic miss;
  } out_item_t;

  // Query probe travelling along the cell row
  typedef struct packed {
    logic valid;
    logic found;
    q16_t q;
    q16_t x0;
    q16_t x1;
    q16_t y0;
    q16_t y1;
  } probe_t;

  // Status of the arithmetic unit
  typedef struct packed {
    logic idle;
    logic done;
  } arith_status_t;

endpackage

/* hw/rtl/pli_cell.sv */
// One breakpoint cell: holds a pair and tests the passing probe against its interval.
`timescale 1ns / 1ps

module pli_cell
  import pli_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  q16_t   wr_x,
  input  q16_t   wr_y,
  input  logic   active,
  input  q16_t   next_x,
  input  q16_t   next_y,
  output q16_t   cell_x,
  output q16_t   cell_y,
  input  probe_t probe_in,
  output probe_t probe_out
);

  q16_t   bp_x;
  q16_t   bp_y;
  probe_t probe;
  logic   hit;

  // Store the breakpoint
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bp_x <= wr_x;
      bp_y <= wr_y;
    end
  end

  // Advance the probe one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      probe.valid <= 1'b0;
    end else begin
      probe.valid <= probe_in.valid;
    end
    probe.found <= probe_in.found;
    probe.q     <= probe_in.q;
    probe.x0    <= probe_in.x0;
    probe.x1    <= probe_in.x1;
    probe.y0    <= probe_in.y0;
    probe.y1    <= probe_in.y1;
  end

  // Claim the probe on the first closed interval that holds it
  assign hit = probe.valid && !probe.found && active &&
               (probe.q >= bp_x) && (probe.q <= next_x);

  always_comb begin
    probe_out = probe;
    if (hit) begin
      probe_out.found = 1'b1;
      probe_out.x0    = bp_x;
      probe_out.x1    = next_x;
      probe_out.y0    = bp_y;
      probe_out.y1    = next_y;
    end
  end

  assign cell_x = bp_x;
  assign cell_y = bp_y;

endmodule

/* hw/rtl/pli_arith.sv */
// Interpolation arithmetic: differences, multiply, radix-4 division, saturation, output register.
`timescale 1ns / 1ps

module pli_arith
  import pli_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  probe_t        probe,
  output arith_status_t status,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_DIFF = 3'd1;
  localparam logic [2:0] PH_MUL  = 3'd2;
  localparam logic [2:0] PH_DIV  = 3'd3;
  localparam logic [2:0] PH_FIN  = 3'd4;

  logic [2:0]           phase;
  logic [DIV_CNT_W-1:0] div_cnt;
  probe_t               hold;
  logic [DATA_W-1:0]    span;
  logic [DATA_W-1:0]    off;
  logic [DATA_W-1:0]    mag;
  logic                 neg;
  logic                 zero_span;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    low;
  logic [DATA_W-1:0]    rem_next;
  logic [DATA_W-1:0]    low_next;
  logic [DATA_W:0]      dx_span;
  logic [DATA_W:0]      dx_off;
  logic [DATA_W:0]      dy;
  logic [DATA_W:0]      dy_abs;
  logic [2*DATA_W-1:0]  product;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W+1:0]    sum;
  out_item_t            result;
  logic                 load_out;

  // Differences of the claimed interval
  assign dx_span = {hold.x1[DATA_W-1], hold.x1} - {hold.x0[DATA_W-1], hold.x0};
  assign dx_off  = {hold.q[DATA_W-1], hold.q} - {hold.x0[DATA_W-1], hold.x0};
  assign dy      = {hold.y1[DATA_W-1], hold.y1} - {hold.y0[DATA_W-1], hold.y0};
  assign dy_abs  = dy[DATA_W] ? ((DATA_W+1)'(0) - dy) : dy;

  assign product = (2*DATA_W)'(mag) * (2*DATA_W)'(off);

  // Restoring division, two quotient bits per cycle; quotient shifts into low
  always_comb begin
    logic [DATA_W:0] trial;
    logic            qbit;
    rem_next = rem;
    low_next = low;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_next, low_next[DATA_W-1]};
      if (trial >= {1'b0, span}) begin
        trial = trial - {1'b0, span};
        qbit  = 1'b1;
      end else begin
        qbit  = 1'b0;
      end
      rem_next = trial[DATA_W-1:0];
      low_next = {low_next[DATA_W-2:0], qbit};
    end
  end

  // Apply the signed step to y0 and saturate
  assign quo = zero_span ? '0 : low;
  assign sum = neg ? ({{2{hold.y0[DATA_W-1]}}, hold.y0} - {2'b00, quo})
                   : ({{2{hold.y0[DATA_W-1]}}, hold.y0} + {2'b00, quo});

  always_comb begin
    result.miss = !hold.found;
    priority if (!hold.found) begin
      result.result_y = '0;
    end else if (sum[DATA_W+1] && !(&sum[DATA_W:DATA_W-1])) begin
      result.result_y = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (!sum[DATA_W+1] && (|sum[DATA_W:DATA_W-1])) begin
      result.result_y = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      result.result_y = sum[DATA_W-1:0];
    end
  end

  assign load_out = (phase == PH_FIN) && (!out_valid || out_ready);

  // Sequence one query through the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      div_cnt <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (probe.valid) begin
            phase <= PH_DIFF;
          end
        end
        PH_DIFF: phase <= PH_MUL;
        PH_MUL: begin
          phase   <= PH_DIV;
          div_cnt <= '0;
        end
        PH_DIV: begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            phase <= PH_FIN;
          end
        end
        PH_FIN: begin
          if (load_out) begin
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && probe.valid) begin
      hold <= probe;
    end
    if (phase == PH_DIFF) begin
      span      <= dx_span[DATA_W-1:0];
      off       <= dx_off[DATA_W-1:0];
      mag       <= dy_abs[DATA_W-1:0];
      neg       <= dy[DATA_W];
      zero_span <= (hold.x1 == hold.x0);
    end
    if (phase == PH_MUL) begin
      rem <= product[2*DATA_W-1:DATA_W];
      low <= product[DATA_W-1:0];
    end
    if (phase == PH_DIV) begin
      rem <= rem_next;
      low <= low_next;
    end
  end

  // Output register; hold the result until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_data <= result;
    end
  end

  assign status.idle = (phase == PH_IDLE);
  assign status.done = load_out;

endmodule

/* hw/rtl/piecewise_linear_interpolator.sv */
// Top level of the piecewise linear interpolator: cell row, control and arithmetic unit.
`timescale 1ns / 1ps

// Breakpoints (x, y), signed Q16.16, sit one per cell in a row of MAX_POINTS cells; a write
// item (kind 0) stores one pair and gives no result, and slots at or above MAX_POINTS are
// ignored. A query item (kind 1) enters the first cell as a probe that moves one cell per
// clock; the first active cell whose closed range [x[i], x[i+1]] holds the query claims it.
// The claimed interval then goes through a difference stage, one 32x32 multiply and a
// restoring divider that resolves two quotient bits per cycle. A query occupies the block
// from its transfer through the walk along the cell row and the divider until its result is
// loaded into the output register; no new item is taken during that time. A finished result
// waits in an output register, so the next item is taken while it waits. point_count
// (reset 2) selects how many breakpoints are in use; the user must write it through
// cfg_write_en / cfg_write_data only while the block is idle; the block does not enforce this.
// Reading a slot that was never written gives an undefined result.
module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_write_en,
  input  logic [COUNT_W-1:0] cfg_write_data
);

  logic [COUNT_W-1:0] point_count;
  logic               busy;
  logic               in_fire;
  logic               query_fire;
  probe_t             chain [MAX_POINTS+1];
  q16_t               cell_xs [MAX_POINTS];
  q16_t               cell_ys [MAX_POINTS];
  arith_status_t      arith_status;

  assign in_fire    = in_valid && in_ready;
  assign query_fire = in_fire && (in_data.kind == KIND_QUERY);
  assign in_ready   = !busy;

  // Breakpoint count register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RESET;
    end else if (cfg_write_en) begin
      point_count <= cfg_write_data;
    end
  end

  // Hold off new items from a query transfer until its result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (query_fire) begin
      busy <= 1'b1;
    end else if (arith_status.done) begin
      busy <= 1'b0;
    end
  end

  // Inject the query probe into the first cell
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = query_fire;
    chain[0].q     = in_data.query_x;
  end

  // Row of breakpoint cells
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic active;
    logic wr_en;
    q16_t next_x;
    q16_t next_y;

    // Interval i is in use when i + 1 is below the clamped count
    assign active = (i + 1 < MAX_POINTS) &&
                    ((i == 0) || (32'(point_count) > i + 1));
    assign wr_en  = in_fire && (in_data.kind == KIND_WRITE) &&
                    (32'(in_data.point_index) == i);

    if (i + 1 < MAX_POINTS) begin : g_nb
      assign next_x = cell_xs[i+1];
      assign next_y = cell_ys[i+1];
    end else begin : g_end
      assign next_x = '0;
      assign next_y = '0;
    end

    pli_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en),
      .wr_x      (in_data.point_x),
      .wr_y      (in_data.point_y),
      .active    (active),
      .next_x    (next_x),
      .next_y    (next_y),
      .cell_x    (cell_xs[i]),
      .cell_y    (cell_ys[i]),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
  end

  pli_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .probe     (chain[MAX_POINTS]),
    .status    (arith_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // A probe leaving the row must find the arithmetic unit free
  assert property (@(posedge clk) disable iff (rst)
    chain[MAX_POINTS].valid |-> arith_status.idle)
    else $error("probe reached a busy arithmetic unit");

  // A query transfer blocks the next item
  assert property (@(posedge clk) disable iff (rst)
    query_fire |=> !in_ready)
    else $error("input ready right after a query transfer");

  // A result appears only after the arithmetic unit finished one
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(arith_status.done))
    else $error("result without a finished query");

  // No probe in the row while the block takes items
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !chain[MAX_POINTS].valid)
    else $error("input ready while a query is in flight");
`endif

endmodule

/* sim/piecewise_linear_interpolator_tb.sv */
// Self-checking testbench for the piecewise linear interpolator.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_tb;
  import pli_pkg::*;

  localparam int SLOTS         = 16;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 44;
  localparam q16_t Q_MIN       = 32'sh8000_0000;
  localparam q16_t Q_MAX       = 32'sh7fff_ffff;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  in_item_t           in_data        = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  out_item_t          out_data;
  logic               cfg_write_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_write_data = '0;

  // Traffic shaping flags, set by the stimulus process
  logic quiet    = 1'b0;
  logic hold_req = 1'b0;

  in_item_t           queued_items[$];
  out_item_t          expected_answers[$];
  q16_t               bp_x[SLOTS];
  q16_t               bp_y[SLOTS];
  logic [COUNT_W-1:0] count_reg = POINT_COUNT_RESET;
  q16_t               plan_x[SLOTS];
  int                 phase_counts[6] = '{16, 2, 1, 17, 31, 9};

  int errors          = 0;
  int items_sent      = 0;
  int queries_sent    = 0;
  int oor_seen        = 0;
  int flat_hits       = 0;
  int results_checked = 0;
  int hold_cnt        = 0;
  bit hold_done       = 1'b0;

  always #5 clk = ~clk;

  piecewise_linear_interpolator u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Clamp the count register to the usable number of breakpoints
  function automatic int active_points();
    int n;
    n = int'(count_reg);
    if (n < 2) n = 2;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // Apply one accepted transfer to the table; queue the answer of a query
  function automatic void interpolate(input in_item_t it);
    out_item_t   ans;
    longint      q, x0, x1, y0, y1, dy, r;
    logic [63:0] span, off, mag, quo;
    bit          hit;
    ans = '0;
    hit = 1'b0;
    r   = 0;
    if (it.kind == KIND_WRITE) begin
      bp_x[it.point_index] = it.point_x;
      bp_y[it.point_index] = it.point_y;
      return;
    end
    q = it.query_x;
    // First interval whose closed range holds q wins; descending ones never match
    for (int i = 0; i + 1 < active_points() && !hit; i++) begin
      x0 = bp_x[i];
      x1 = bp_x[i + 1];
      if (q >= x0 && q <= x1) begin
        hit  = 1'b1;
        y0   = bp_y[i];
        y1   = bp_y[i + 1];
        span = x1 - x0;
        off  = q - x0;
        dy   = y1 - y0;
        mag  = (dy < 0) ? -dy : dy;
        if (span == 0) begin
          r = y0;
          flat_hits++;
        end else begin
          quo = (mag * off) / span;
          r   = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
        end
      end
    end
    if (r > longint'(Q_MAX)) r = longint'(Q_MAX);
    if (r < longint'(Q_MIN)) r = longint'(Q_MIN);
    ans.miss     = !hit;
    ans.result_y = hit ? r[31:0] : '0;
    expected_answers.push_back(ans);
    queries_sent++;
  endfunction

  // Driver: offer the next queued item, hold it until the transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        interpolate(in_data);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (queued_items.size() > 0 && (quiet || $urandom_range(0, 99) >= 36)) begin
          in_valid <= 1'b1;
          in_data  <= queued_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest answer
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (out_data.miss) oor_seen++;
        if (expected_answers.size() == 0) begin
          report_mismatch($sformatf("result y=%0d miss=%b with nothing pending",
                                    out_data.result_y, out_data.miss));
        end else begin
          want = expected_answers.pop_front();
          if (out_data.result_y !== want.result_y)
            report_mismatch($sformatf("result_y %0d, expected %0d",
                                      out_data.result_y, want.result_y));
          if (out_data.miss !== want.miss)
            report_mismatch($sformatf("miss %b, expected %b",
                                      out_data.miss, want.miss));
        end
      end
      // One long hold-off so the block backs up into its input
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || $urandom_range(0, 99) >= 36;
      end
    end
  end

  task automatic push_write(input int idx, input q16_t x, input q16_t y);
    in_item_t it;
    it             = '0;
    it.kind        = KIND_WRITE;
    it.point_index = 4'(idx);
    it.point_x     = x;
    it.point_y     = y;
    it.query_x     = $urandom;
    queued_items.push_back(it);
    plan_x[idx] = x;
  endtask

  task automatic push_query(input q16_t q);
    in_item_t it;
    it             = '0;
    it.kind        = KIND_QUERY;
    it.point_index = 4'($urandom_range(0, 15));
    it.point_x     = $urandom;
    it.point_y     = $urandom;
    it.query_x     = q;
    queued_items.push_back(it);
  endtask

  // Wait until every item is taken and answered, then let the block drain
  task automatic settle();
    do @(posedge clk);
    while (queued_items.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input int value);
    settle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= COUNT_W'(value);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    count_reg = COUNT_W'(value);
  endtask

  // Rewrite the active slots with mostly rising x, some flat and backward steps
  task automatic reload_table();
    longint cur;
    int     n;
    n   = active_points();
    cur = ($urandom_range(0, 3) == 0) ? longint'(Q_MIN) : longint'($signed($urandom)) / 2;
    for (int i = 0; i < n; i++) begin
      push_write(i, cur[31:0], $urandom);
      case ($urandom_range(0, 9))
        0: ;
        1: cur = cur - int'($urandom_range(1, 4096));
        2, 3, 4: cur = cur + int'($urandom_range(1, 65536));
        default: cur = cur + int'($urandom_range(1, 1 << 28));
      endcase
      if (cur > longint'(Q_MAX)) cur = longint'(Q_MAX);
      if (cur < longint'(Q_MIN)) cur = longint'(Q_MIN);
    end
  endtask

  // Aim at breakpoints, inside intervals, just below them, or anywhere
  function automatic q16_t pick_query();
    int          n, i;
    longint      lo, hi;
    logic [63:0] spread;
    n  = active_points();
    i  = $urandom_range(0, n - 2);
    lo = plan_x[i];
    hi = plan_x[i + 1];
    case ($urandom_range(0, 9))
      0, 1, 2: return plan_x[$urandom_range(0, n - 1)];
      3, 4, 5, 6: begin
        if (hi < lo) return plan_x[i];
        spread = {$urandom, $urandom};
        return q16_t'(lo + longint'(spread % (hi - lo + 1)));
      end
      7: return q16_t'(lo - 1);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Table: short rising pair, backward step into a flat point, one interval
    // over the whole x range, filler, and the top slot at the extremes
    push_write(0, 32'sd655360, Q_MAX);
    push_write(1, 32'sd1310720, Q_MIN);
    push_write(2, 32'sd327680, 32'sd196608);
    push_write(3, 32'sd327680, -32'sd42);
    push_write(4, Q_MIN, 32'sd1000);
    push_write(5, Q_MAX, -32'sd1000);
    for (int i = 6; i < SLOTS - 1; i++) push_write(i, i * 1000, -i * 777);
    push_write(15, Q_MAX, Q_MIN);

    // Reset count: only the first interval is live
    push_query(32'sd655360);
    push_query(32'sd1310720);
    push_query(32'sd983040);
    push_query(Q_MIN);
    push_query(Q_MAX);

    // Count zero behaves as two
    set_count(0);
    push_query(32'sd327680);

    // Skip the backward interval, land on the flat one, miss just past it
    set_count(4);
    push_query(32'sd327680);
    push_query(32'sd400000);

    // Count past the table behaves as the full table
    set_count(31);
    push_query(Q_MIN);
    push_query(Q_MAX);
    push_query(32'sd0);

    // Random phases: reload the table except in phase 7, then queries with stray writes
    for (int p = 0; p < PHASES; p++) begin
      set_count(p < 6 ? phase_counts[p] : int'($urandom_range(0, 31)));
      quiet <= (p == 5);
      if (p == 3) hold_req <= 1'b1;
      if (p != 7) reload_table();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) < 2) push_write($urandom_range(0, 15), $urandom, $urandom);
        else push_query(pick_query());
      end
    end
    settle();

    $display("tb: %0d items sent, %0d queries, %0d results checked", items_sent,
             queries_sent, results_checked);
    $display("tb: %0d queries outside the table, %0d flat intervals hit, counts from zero "
             , oor_seen, flat_hits, "to past the table exercised");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
